FILE: rtl/core/bta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the block table allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int ADDR_W     = 32;

   typedef enum logic [1:0] {
      RSP_DONE = 2'd0,
      RSP_FULL = 2'd1,
      RSP_MISS = 2'd2
   } rsp_code_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] req_size;
      logic [ADDR_W-1:0] req_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] alloc_addr;
      rsp_code_type      status;
   } rsp_type;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ASCAN,
      S_AWRITE,
      S_FSCAN,
      S_FCOPY
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_ASCAN,
      OP_AWRITE,
      OP_FSCAN,
      OP_FCOPY
   } dp_op_type;

   typedef struct packed {
      dp_op_type    op;
      logic         respond;
      rsp_code_type code;
   } cmd_type;

   typedef struct packed {
      logic req_free;
      logic req_null;
      logic full;
      logic empty;
      logic ascan_done;
      logic free_hit;
      logic free_miss;
      logic copy_done;
   } dp_status_type;

endpackage

FILE: rtl/core/block_table_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_table_allocator
// Allocation table of base/size blocks with first-fit style allocate and free.
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  request   start, busy, req_item    beat taken when start high and busy low
//  result    rsp_strobe, rsp_item     one cycle strobe, no back-pressure
//  config    csr_we, csr_wdata        heap_start written when csr_we high
//
//  allocate reads the live entries oldest first (one table read a cycle),
//  then writes the insert; on an empty table it goes straight to the insert.
//  free scans newest first, then makes one copy a cycle to close the gap.
//  refusals, null frees and frees on an empty table are answered without
//  going busy. the result strobe is registered and comes in the cycle after the last busy cycle.
//  synchronous reset empties the table at once, no clearing pass.
// ----------------------------------------------------------------------------
module block_table_allocator
   import bta_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_wdata,
   output logic              rsp_strobe,
   output rsp_type           rsp_item
);

   cmd_type       cmd;
   dp_status_type status;

   bta_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   bta_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

FILE: rtl/core/bta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_ctrl
// Sequencer: decides each request and steps the datapath through its passes.
// ----------------------------------------------------------------------------
module bta_ctrl
   import bta_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.op      = OP_NONE;
      cmd.respond = 1'b0;
      cmd.code    = RSP_DONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (status.req_free == KIND_ALLOC) begin
                  if (status.full) begin
                     cmd.respond = 1'b1;
                     cmd.code    = RSP_FULL;
                  end else begin
                     cmd.op   = OP_LOAD;
                     state_in = status.empty ? S_AWRITE : S_ASCAN;
                  end
               end else begin
                  if (status.req_null || status.empty) begin
                     cmd.respond = 1'b1;
                     cmd.code    = RSP_MISS;
                  end else begin
                     cmd.op   = OP_LOAD;
                     state_in = S_FSCAN;
                  end
               end
            end
         end
         S_ASCAN: begin
            cmd.op = OP_ASCAN;
            if (status.ascan_done) begin
               state_in = S_AWRITE;
            end
         end
         S_AWRITE: begin
            cmd.op      = OP_AWRITE;
            cmd.respond = 1'b1;
            cmd.code    = RSP_DONE;
            state_in    = S_IDLE;
         end
         S_FSCAN: begin
            cmd.op = OP_FSCAN;
            if (status.free_hit) begin
               state_in = S_FCOPY;
            end else if (status.free_miss) begin
               cmd.respond = 1'b1;
               cmd.code    = RSP_MISS;
               state_in    = S_IDLE;
            end
         end
         S_FCOPY: begin
            cmd.op = OP_FCOPY;
            if (status.copy_done) begin
               cmd.respond = 1'b1;
               cmd.code    = RSP_DONE;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: rtl/core/bta_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_datapath
// Entry table memory, scan pointer, candidate address and result register.
// ----------------------------------------------------------------------------
module bta_datapath
   import bta_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_item,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_wdata,
   input  cmd_type           cmd,
   output dp_status_type     status,
   output logic              rsp_strobe,
   output rsp_type           rsp_item
);

   // table kept oldest first: physical slot 0 is the oldest entry
   logic [2*ADDR_W-1:0] mem [MAX_BLOCKS];

   logic [ADDR_W-1:0]   heap_ff;
   logic [CNT_W-1:0]    count_ff,  count_in;
   logic [CNT_W-1:0]    ptr_ff,    ptr_in;
   logic [ADDR_W-1:0]   cand_ff,   cand_in;
   logic [ADDR_W-1:0]   size_ff,   size_in;
   logic [ADDR_W-1:0]   addr_ff,   addr_in;
   logic [2*ADDR_W-1:0] rd_data_ff;
   logic                rvalid_ff, rvalid_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                last_ff,   last_in;
   logic                strobe_ff, strobe_in;
   rsp_type             rsp_ff,    rsp_in;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [2*ADDR_W-1:0] mem_wdata;
   logic                issue;

   logic [ADDR_W-1:0]   rd_base;
   logic [ADDR_W-1:0]   rd_size;
   logic [ADDR_W:0]     entry_end;
   logic [ADDR_W:0]     cand_end;
   logic                overlap;
   logic                match;

   assign rd_base   = rd_data_ff[2*ADDR_W-1:ADDR_W];
   assign rd_size   = rd_data_ff[ADDR_W-1:0];
   assign entry_end = {1'b0, rd_base} + {1'b0, rd_size};
   assign cand_end  = {1'b0, cand_ff} + {1'b0, size_ff};
   // either base inside the other range, sums one bit wider so they never wrap
   assign overlap   = ((cand_ff >= rd_base) && ({1'b0, cand_ff} < entry_end)) ||
                      ((rd_base >= cand_ff) && ({1'b0, rd_base} < cand_end));
   assign match     = (rd_base == addr_ff);

   always_comb begin
      case (cmd.op)
         OP_ASCAN, OP_FCOPY: issue = (ptr_ff < count_ff);
         OP_FSCAN:           issue = !last_ff;
         default:            issue = 1'b0;
      endcase
   end

   always_comb begin
      status.req_free   = req_item.kind;
      status.req_null   = (req_item.req_addr == '0);
      status.full       = (count_ff >= CNT_W'(MAX_BLOCKS));
      status.empty      = (count_ff == '0);
      status.ascan_done = (ptr_ff == count_ff) && rvalid_ff;
      status.free_hit   = rvalid_ff && match;
      status.free_miss  = rvalid_ff && !match && (rd_idx_ff == '0);
      status.copy_done  = (ptr_ff == count_ff);
   end

   always_comb begin
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      cand_in   = cand_ff;
      size_in   = size_ff;
      addr_in   = addr_ff;
      rvalid_in = issue;
      rd_idx_in = issue ? ptr_ff[IDX_W-1:0] : rd_idx_ff;
      last_in   = last_ff;
      mem_we    = 1'b0;
      mem_waddr = count_ff[IDX_W-1:0];
      mem_wdata = {cand_ff, size_ff};
      case (cmd.op)
         OP_LOAD: begin
            size_in   = req_item.req_size;
            addr_in   = req_item.req_addr;
            cand_in   = heap_ff;
            rvalid_in = 1'b0;
            last_in   = 1'b0;
            ptr_in    = (req_item.kind == KIND_ALLOC) ? '0 : count_ff - CNT_W'(1);
         end
         OP_ASCAN: begin
            if (issue) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (rvalid_ff && overlap) begin
               cand_in = entry_end[ADDR_W-1:0];
            end
         end
         OP_AWRITE: begin
            mem_we   = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
         OP_FSCAN: begin
            // newest first, so the first match seen is the one to drop
            if (issue) begin
               ptr_in = ptr_ff - CNT_W'(1);
               if (ptr_ff == '0) begin
                  last_in = 1'b1;
               end
            end
            if (rvalid_ff && match) begin
               ptr_in    = CNT_W'(rd_idx_ff) + CNT_W'(1);
               rvalid_in = 1'b0;
            end
         end
         OP_FCOPY: begin
            // entries above the hole move down one slot
            if (issue) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (rvalid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_idx_ff - IDX_W'(1);
               mem_wdata = rd_data_ff;
            end
            if (status.copy_done) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      strobe_in = cmd.respond;
      rsp_in    = rsp_ff;
      if (cmd.respond) begin
         rsp_in.alloc_addr = (cmd.op == OP_AWRITE) ? cand_ff : '0;
         rsp_in.status     = cmd.code;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (issue) begin
         rd_data_ff <= mem[ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff   <= '0;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         last_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            heap_ff <= csr_wdata;
         end
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
         last_ff   <= last_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      cand_ff   <= cand_in;
      size_ff   <= size_in;
      addr_ff   <= addr_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

FILE: rtl/core/bta_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_checker
// Port-level checks of the block table allocator.
// ----------------------------------------------------------------------------
module bta_checker
   import bta_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input req_type           req_item,
   input logic              rsp_strobe,
   input rsp_type           rsp_item
);

   // results only come out once the sequencer is back idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_fail_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status != RSP_DONE)) |-> (rsp_item.alloc_addr == '0))
      else $error("refused or missed beat carries an address");

   a_null_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.kind == KIND_FREE) && (req_item.req_addr == '0))
      |=> (rsp_strobe && (rsp_item.status == RSP_MISS)))
      else $error("null free not answered at once");

   a_alloc_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.kind == KIND_ALLOC)) |=> (rsp_strobe || busy))
      else $error("allocate neither refused nor started");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("activity straight after reset");

endmodule

bind block_table_allocator bta_checker u_bta_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the block table allocator. Allocate and free beats
// go in through the start/busy handshake. A bench-side copy of the table
// predicts every result. Each strobed result is checked field by field
// against the oldest prediction. Directed edge cases come first, then
// phases of random traffic, each under its own heap start setting.
// ----------------------------------------------------------------------------
module tb_top;
   import bta_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 2 * MAX_BLOCKS + 20;
   localparam int PRINT_CAP   = 50;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_item;
   logic              csr_we;
   logic [ADDR_W-1:0] csr_wdata;
   logic              rsp_strobe;
   rsp_type           rsp_item;

   // bench copy of the allocation table
   logic [ADDR_W-1:0] table_base [MAX_BLOCKS];
   logic [ADDR_W-1:0] table_size [MAX_BLOCKS];
   int                table_count;
   logic [ADDR_W-1:0] model_heap_start;

   rsp_type pending_rsp [$];
   int      error_count;
   int      quiet_cycles;

   block_table_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                  input logic [ADDR_W-1:0] got);
      if (error_count < PRINT_CAP)
         $display("mismatch %s: expected %h got %h", what, want, got);
      error_count++;
   endtask

   // ---- predictor -----------------------------------------------------------

   // sums taken one bit wider so the end of a range never wraps
   function automatic bit range_holds(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size,
                                      logic [ADDR_W-1:0] addr);
      return (addr >= base) && ({1'b0, addr} < ({1'b0, base} + {1'b0, size}));
   endfunction

   function automatic rsp_type predict_alloc(logic [ADDR_W-1:0] size);
      rsp_type           r;
      logic [ADDR_W-1:0] cand;
      int                k;
      r.alloc_addr = '0;
      r.status     = RSP_FULL;
      if (table_count >= MAX_BLOCKS)
         return r;
      cand = model_heap_start;
      // oldest entry first
      for (k = table_count - 1; k >= 0; k--) begin
         if (range_holds(cand, size, table_base[k]) ||
             range_holds(table_base[k], table_size[k], cand))
            cand = table_base[k] + table_size[k];
      end
      for (k = table_count; k > 0; k--) begin
         table_base[k] = table_base[k-1];
         table_size[k] = table_size[k-1];
      end
      table_base[0] = cand;
      table_size[0] = size;
      table_count++;
      r.alloc_addr = cand;
      r.status     = RSP_DONE;
      return r;
   endfunction

   function automatic rsp_type predict_free(logic [ADDR_W-1:0] addr);
      rsp_type r;
      int      hit;
      int      k;
      r.alloc_addr = '0;
      r.status     = RSP_MISS;
      hit          = -1;
      if (addr == '0)
         return r;
      for (k = 0; k < table_count; k++) begin
         if (hit < 0 && table_base[k] == addr)
            hit = k;
      end
      if (hit < 0)
         return r;
      for (k = hit; k + 1 < table_count; k++) begin
         table_base[k] = table_base[k+1];
         table_size[k] = table_size[k+1];
      end
      table_count--;
      r.status = RSP_DONE;
      return r;
   endfunction

   function automatic rsp_type predict_request(req_type item);
      if (item.kind == KIND_ALLOC)
         return predict_alloc(item.req_size);
      return predict_free(item.req_addr);
   endfunction

   // ---- stimulus helpers ----------------------------------------------------

   function automatic req_type make_req(logic kind, logic [ADDR_W-1:0] size,
                                        logic [ADDR_W-1:0] addr);
      req_type item;
      item.kind     = kind;
      item.req_size = size;
      item.req_addr = addr;
      return item;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 60) return $urandom_range(1, 256);
      if (r < 80) return $urandom_range(257, 65535);
      if (r < 95) return $urandom;
      return 32'hFFFF_FFFF - $urandom_range(0, 255);
   endfunction

   // frees mostly name a live block; the rest are null or stray addresses
   function automatic req_type random_req(int alloc_pct);
      req_type item;
      int      r;
      item = make_req(KIND_ALLOC, pick_size(), $urandom);
      if ($urandom_range(0, 99) >= alloc_pct) begin
         item.kind     = KIND_FREE;
         item.req_size = $urandom;
         r = $urandom_range(0, 9);
         if (r == 0)
            item.req_addr = '0;
         else if (r >= 2 && table_count > 0)
            item.req_addr = table_base[$urandom_range(0, table_count - 1)];
      end
      return item;
   endfunction

   // start is left high after the beat so back-to-back requests never drop it
   task automatic send_req(input req_type item);
      req_item <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_request(item));
   endtask

   task automatic sender_gap(input bit enabled);
      if (enabled && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic wait_results_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_heap_start(input logic [ADDR_W-1:0] value);
      wait_results_idle();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      model_heap_start = value;
   endtask

   // ---- tests ---------------------------------------------------------------

   // empty table, heap start at its reset value of zero
   task automatic test_edge_requests();
      send_req(make_req(KIND_FREE,  32'hFFFF_FFFF, 32'h0000_0040)); // miss on empty table
      send_req(make_req(KIND_FREE,  32'h0000_0000, 32'h0000_0000)); // null
      send_req(make_req(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000)); // address zero handed out
      send_req(make_req(KIND_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF));
      // zero-size blocks hold nothing, but this range holds their base
      send_req(make_req(KIND_ALLOC, 32'h0000_0010, 32'h0000_0000));
      send_req(make_req(KIND_ALLOC, 32'h0000_0010, 32'h0000_0000));
      send_req(make_req(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_req(make_req(KIND_FREE,  32'h0000_0000, 32'h0000_0000));
      send_req(make_req(KIND_FREE,  32'hFFFF_FFFF, 32'h0000_0010));
      send_req(make_req(KIND_FREE,  32'h0000_0000, 32'hFFFF_FFFF));
      sender_gap(1'b1);
   endtask

   task automatic test_address_wrap();
      write_heap_start(32'hFFFF_FFF0);
      send_req(make_req(KIND_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000));
      // candidate steps past the top and wraps round
      send_req(make_req(KIND_ALLOC, 32'h0000_0020, 32'h0000_0000));
      send_req(make_req(KIND_ALLOC, 32'h0000_0001, 32'hFFFF_FFFF));
      send_req(make_req(KIND_FREE,  32'h0000_0000, 32'hFFFF_FFF0));
      send_req(make_req(KIND_FREE,  32'h0000_0000, 32'hFFFF_FFEF));
      write_heap_start(32'hFFFF_FFFF);
      send_req(make_req(KIND_ALLOC, 32'h0000_0000, 32'h0000_0000));
      send_req(make_req(KIND_ALLOC, 32'h0000_0001, 32'h0000_0000));
      send_req(make_req(KIND_ALLOC, 32'h0000_0008, 32'h0000_0000));
      send_req(make_req(KIND_FREE,  32'h0000_0000, 32'hFFFF_FFFF));
      send_req(make_req(KIND_FREE,  32'h0000_0000, 32'h0000_0007));
   endtask

   // even phases lean to allocate and run the table full, odd ones drain it
   task automatic test_random_traffic();
      logic [ADDR_W-1:0] heap_list [5];
      int                phase;
      int                n;
      heap_list = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h8000_0000,
                    $urandom_range(0, 4096)};
      for (phase = 0; phase < 5; phase++) begin
         write_heap_start(heap_list[phase]);
         for (n = 0; n < 150; n++) begin
            if (n == 75)
               wait_results_idle();
            send_req(random_req((phase % 2 == 0) ? 75 : 35));
            sender_gap((n / 30) % 2 == 0);
         end
      end
   endtask

   // closing stretch, beats offered back to back
   task automatic test_streaming();
      int n;
      write_heap_start(32'h0000_0000);
      for (n = 0; n < 150; n++)
         send_req(random_req(55));
   endtask

   task automatic finish_run();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("block_table_allocator regression: pass");
      else
         $display("block_table_allocator regression: fail");
      $finish;
   endtask

   // ---- result checking and watchdog ----------------------------------------

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with no request", '0, rsp_item.alloc_addr);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.alloc_addr !== want.alloc_addr)
               report_mismatch("alloc_addr", want.alloc_addr, rsp_item.alloc_addr);
            if (rsp_item.status !== want.status)
               report_mismatch("status", ADDR_W'(want.status), ADDR_W'(rsp_item.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("block_table_allocator regression: fail");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_item         = '0;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      error_count      = 0;
      quiet_cycles     = 0;
      table_count      = 0;
      model_heap_start = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_edge_requests();
      test_address_wrap();
      test_random_traffic();
      test_streaming();
      finish_run();
   end

endmodule

FILE: sim.f
rtl/core/bta_pkg.sv
rtl/core/bta_ctrl.sv
rtl/core/bta_datapath.sv
rtl/core/block_table_allocator.sv
rtl/core/bta_checker.sv
bench/tb_top.sv
